@@ design/sis_pkg.sv @@
// Shared types and defaults for the stable insertion sorter.
`default_nettype none

package sis_pkg;

  // Defaults for the top-level parameters
  localparam int CAPACITY_DEF   = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed width of the value ports
  localparam int VALUE_W = 32;

  // Per-cycle command broadcast along the chain of cells
  typedef struct packed {
    logic insert;     // place the incoming request in order
    logic shift_out;  // move every entry one cell towards the head
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ design/sis_cell.sv @@
// One cell of the sorting chain: holds a single element and its valid bit.
`default_nettype none

module sis_cell
  import sis_pkg::*;
#(
  parameter int DataWidth = DATA_WIDTH_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_cmd_t            cmd,
  input  wire logic [DataWidth-1:0] new_data,
  input  wire logic [DataWidth-1:0] left_data,
  input  wire logic                 left_valid,
  input  wire logic                 left_greater,
  input  wire logic [DataWidth-1:0] right_data,
  input  wire logic                 right_valid,
  output logic [DataWidth-1:0]      data,
  output logic                      valid,
  output logic                      greater
);

  logic                 take;
  logic [DataWidth-1:0] data_next;
  logic                 valid_next;

  // Flag a held element that the incoming one must pass (strictly less keeps order stable)
  assign greater = valid && ($signed(new_data) < $signed(data));

  // Take a new element when it displaces ours, or when we are the first free cell
  assign take = greater || (!valid && left_valid);

  // Choose the next contents
  always_comb begin
    data_next  = data;
    valid_next = valid;
    if (cmd.shift_out) begin
      data_next  = right_data;
      valid_next = right_valid;
    end else if (cmd.insert && take) begin
      data_next  = left_greater ? left_data : new_data;
      valid_next = 1'b1;
    end
  end

  // Hold the element
  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Clear occupancy on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

`default_nettype wire

@@ design/stable_insertion_sorter.sv @@
// Stable insertion sorter: a chain of cells kept in ascending order, drained from the head.
// Loading: one request accepted per cycle; each is placed in order in the same cycle.
// Draining: the first result appears in the cycle after a set's last request is taken,
//   then one result per cycle (output stall permitting), N results for N held elements.
// Input is stalled while a set drains, until its last result has been taken.
// Reset clears the cell valid bits, the drop flag and the drain state; no data is cleared.
`default_nettype none

module stable_insertion_sorter
  import sis_pkg::*;
#(
  parameter int Capacity  = CAPACITY_DEF,
  parameter int DataWidth = DATA_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [VALUE_W-1:0] value,
  input  wire logic               last_item,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [VALUE_W-1:0] sorted_value,
  output logic                    last_result,
  output logic                    overflow
);

  localparam int WideW = (DataWidth > VALUE_W) ? DataWidth : VALUE_W;

  logic                 draining;
  logic                 draining_next;
  logic                 dropped;
  logic                 dropped_next;
  logic                 in_accept;
  logic                 out_accept;
  logic                 full;
  cell_cmd_t            cmd;
  logic [WideW-1:0]     wide_in;
  logic [WideW-1:0]     wide_out;
  logic [DataWidth-1:0] new_data;

  logic [DataWidth-1:0] cell_data    [Capacity];
  logic                 cell_valid   [Capacity];
  logic                 cell_greater [Capacity];

  // Trim or zero-extend the incoming value to the stored width
  assign wide_in  = WideW'($unsigned(value));
  assign new_data = wide_in[DataWidth-1:0];

  assign full       = cell_valid[Capacity-1];
  assign in_stall   = draining;
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;

  // Broadcast the chain command
  always_comb begin
    cmd.insert    = in_accept && !full;
    cmd.shift_out = out_accept;
  end

  // Build the chain
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic [DataWidth-1:0] l_data;
    logic                 l_valid;
    logic                 l_greater;
    logic [DataWidth-1:0] r_data;
    logic                 r_valid;

    if (i == 0) begin : g_head
      assign l_data    = new_data;
      assign l_valid   = 1'b1;
      assign l_greater = 1'b0;
    end else begin : g_body
      assign l_data    = cell_data[i-1];
      assign l_valid   = cell_valid[i-1];
      assign l_greater = cell_greater[i-1];
    end

    if (i == Capacity - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_next
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end

    sis_cell #(
      .DataWidth(DataWidth)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .new_data    (new_data),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .left_greater(l_greater),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .greater     (cell_greater[i])
    );
  end

  // Advance the drain state and the drop flag
  always_comb begin
    draining_next = draining;
    dropped_next  = dropped;
    if (out_accept && last_result) begin
      draining_next = 1'b0;
      dropped_next  = 1'b0;
    end else if (in_accept) begin
      if (full) begin
        dropped_next = 1'b1;
      end
      if (last_item) begin
        draining_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else begin
      draining <= draining_next;
      dropped  <= dropped_next;
    end
  end

  // Present the head of the chain as the result
  assign wide_out     = WideW'(cell_data[0]);
  assign out_valid    = draining;
  assign sorted_value = wide_out[VALUE_W-1:0];
  assign last_result  = !cell_valid[1];
  assign overflow     = dropped;

  // Occupied cells form an unbroken run from the head
  for (genvar i = 1; i < Capacity; i++) begin : g_chk
    a_contiguous: assert property (@(posedge clk) disable iff (rst)
      cell_valid[i] |-> cell_valid[i-1])
      else $error("cell occupied above a free cell");
  end

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> cell_valid[0])
    else $error("draining with an empty chain");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (out_accept && last_result) |=> (!draining && !cell_valid[0] && !dropped))
    else $error("chain not empty after final result");

  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    $rose(draining) |-> $past(in_accept && last_item))
    else $error("drain started without a final request");

endmodule

`default_nettype wire

@@ tb/sv/sorter_checker.sv @@
`timescale 1ns / 100ps
// Checker for the stable insertion sorter: predicts every sorted set and compares the results.
module sorter_checker
  import sis_pkg::*;
(
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_stall,
  input  wire logic signed [VALUE_W-1:0]   value,
  input  wire logic                        last_item,
  input  wire logic                        out_valid,
  input  wire logic                        out_stall,
  input  wire logic signed [VALUE_W-1:0]   sorted_value,
  input  wire logic                        last_result,
  input  wire logic                        overflow,
  output int                               error_count,
  output int                               pending_count
);

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic                      last;
    logic                      ovf;
  } sorted_result_t;

  // Predicted contents of the sorter for the set being loaded
  logic signed [VALUE_W-1:0] set_store[$];
  logic                      set_dropped = 1'b0;
  sorted_result_t            due_results[$];
  int                        mismatches = 0;

  // Place a request after every equal element; drop it when the store is full
  function automatic void place_element(input logic signed [VALUE_W-1:0] v);
    int pos;
    if (set_store.size() >= CAPACITY_DEF) begin
      set_dropped = 1'b1;
      return;
    end
    pos = set_store.size();
    while (pos > 0 && v < set_store[pos-1]) pos--;
    set_store.insert(pos, v);
  endfunction

  // Queue the whole set in ascending order and empty the store
  function automatic void release_set();
    sorted_result_t r;
    for (int k = 0; k < set_store.size(); k++) begin
      r.val  = set_store[k];
      r.last = (k == set_store.size() - 1);
      r.ovf  = set_dropped;
      due_results.push_back(r);
    end
    set_store.delete();
    set_dropped = 1'b0;
  endfunction

  // Compare results first: a request taken on the same edge only adds later results
  always @(posedge clk) begin
    sorted_result_t want;
    sorted_result_t got;
    if (rst) begin
      set_store.delete();
      set_dropped = 1'b0;
      due_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = '{sorted_value, last_result, overflow};
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result with nothing due: value %0d last %b overflow %b",
                     $time, got.val, got.last, got.ovf);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("[%0t] mismatch: expected value %0d last %b overflow %b, ",
                     $time, want.val, want.last, want.ovf);
              $display("got value %0d last %b overflow %b",
                       got.val, got.last, got.ovf);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        place_element(value);
        if (last_item) release_set();
      end
    end
    error_count   <= mismatches;
    pending_count <= due_results.size();
  end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the stable insertion sorter: clock, reset, request stimulus and verdict.
module tb_top
  import sis_pkg::*;
();

  localparam int IDLE_LIMIT  = 2000;
  localparam int ITEM_TARGET = 270;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

  // Result-side stall patterns
  localparam logic [1:0] STALL_NONE   = 2'd0;
  localparam logic [1:0] STALL_SPARSE = 2'd1;
  localparam logic [1:0] STALL_BURST  = 2'd2;
  localparam logic [1:0] STALL_HEAVY  = 2'd3;

  logic                      clk          = 1'b0;
  logic                      rst          = 1'b1;
  logic                      in_valid     = 1'b0;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value        = '0;
  logic                      last_item    = 1'b0;
  logic                      out_valid;
  logic                      out_stall    = 1'b0;
  logic signed [VALUE_W-1:0] sorted_value;
  logic                      last_result;
  logic                      overflow;
  int                        error_count;
  int                        pending_count;
  int                        idle_cycles  = 0;
  int                        burst_left   = 0;
  int                        items_sent   = 0;
  logic [1:0]                stall_mode   = STALL_NONE;
  int                        mode_cycles  = 0;
  int                        stall_hold   = 0;

  stable_insertion_sorter dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .last_item    (last_item),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflow     (overflow)
  );

  sorter_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .value         (value),
    .last_item     (last_item),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_value  (sorted_value),
    .last_result   (last_result),
    .overflow      (overflow),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stall the result side on a randomly chosen pattern that changes when its hold count runs out
  always @(posedge clk) begin
    if (mode_cycles == 0) begin
      stall_mode  <= 2'($urandom_range(0, 3));
      mode_cycles <= $urandom_range(16, 80);
    end else begin
      mode_cycles <= mode_cycles - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall <= 1'b0;
      end
      STALL_SPARSE: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      STALL_BURST: begin
        if (stall_hold > 0) begin
          out_stall  <= 1'b1;
          stall_hold <= stall_hold - 1;
        end else if ($urandom_range(0, 5) == 0) begin
          out_stall  <= 1'b1;
          stall_hold <= $urandom_range(1, 7);
        end else begin
          out_stall  <= 1'b0;
        end
      end
      STALL_HEAVY: begin
        out_stall <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_stall <= 1'b0;
      end
    endcase
  end

  // End the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Hold a request until taken, then either go on with the burst or leave a gap
  task automatic push_request(input logic signed [VALUE_W-1:0] v, input logic is_last);
    logic taken;
    in_valid  <= 1'b1;
    value     <= v;
    last_item <= is_last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid  <= 1'b0;
      value     <= $urandom;
      last_item <= 1'($urandom_range(0, 1));
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end
  endtask

  // Hold off new requests until every due result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_count != 0);
    @(posedge clk);
  endtask

  // Mix of duplicates, values near the extremes and full-range values
  function automatic logic signed [VALUE_W-1:0] random_value();
    case ($urandom_range(0, 3))
      0: return VALUE_W'($urandom_range(0, 4) - 2);
      1: return $urandom_range(0, 1) ? VALUE_MAX - $urandom_range(0, 2)
                                     : VALUE_MIN + $urandom_range(0, 2);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int set_size;
    int pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Extremes, duplicates and both signs in one set
    push_request(VALUE_MAX, 1'b0);
    push_request(VALUE_MIN, 1'b0);
    push_request('0, 1'b0);
    push_request(-1, 1'b0);
    push_request(1, 1'b0);
    push_request(VALUE_MIN, 1'b1);
    // A set of a single element
    push_request(-5, 1'b1);
    // Overfull set: the store fills and the last request itself is dropped
    for (int k = 0; k < CAPACITY_DEF + 1; k++)
      push_request(k[0] ? -k : 100 - k, k == CAPACITY_DEF);
    drain_results();

    // Random sets, mostly small, some filling or overfilling the store
    while (items_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)      set_size = $urandom_range(1, 6);
      else if (pick < 16) set_size = $urandom_range(7, CAPACITY_DEF - 1);
      else if (pick < 18) set_size = CAPACITY_DEF;
      else                set_size = $urandom_range(CAPACITY_DEF + 1, CAPACITY_DEF + 4);
      for (int k = 0; k < set_size; k++)
        push_request(random_value(), k == set_size - 1);
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    drain_results();
    repeat (16) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/sis_pkg.sv
design/sis_cell.sv
design/stable_insertion_sorter.sv
tb/sv/sorter_checker.sv
tb/sv/tb_top.sv
